@@ rtl/ep2cal_pkg.sv @@
// Shared types, constants and calendar helper functions for the epoch seconds
// to calendar converter. No dependencies.
`timescale 1ns / 1ps

package ep2cal_pkg;

   localparam int unsigned OpW = 33;

   localparam logic [OpW-1:0] DaySecs  = 33'd86400;
   localparam logic [OpW-1:0] HourSecs = 33'd3600;
   localparam logic [OpW-1:0] MinSecs  = 33'd60;
   localparam logic [OpW-1:0] WeekLen  = 33'd7;
   localparam logic [OpW-1:0] LeapLen  = 33'd366;
   localparam logic [OpW-1:0] YearLen  = 33'd365;

   localparam logic [11:0] EpochYear     = 12'd1970;
   localparam logic [11:0] SkipLeapYear  = 12'd2100;
   localparam logic [3:0]  LastMonth     = 4'd11;
   localparam logic [3:0]  FebMonth      = 4'd1;
   localparam logic [3:0]  DayBitTop     = 4'd15;
   localparam logic [3:0]  HourBitTop    = 4'd4;
   localparam logic [3:0]  MinBitTop     = 4'd5;
   localparam logic [3:0]  WdayBitTop    = 4'd13;
   localparam logic [31:0] EpochWeekday  = 32'd4;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DAYS  = 8'b0000_0010,
      ST_HOUR  = 8'b0000_0100,
      ST_MIN   = 8'b0000_1000,
      ST_YEAR  = 8'b0001_0000,
      ST_MONTH = 8'b0010_0000,
      ST_WDAY  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [OpW-1:0] diff;
      logic           ge;
   } sub_out_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } cal_type;

   // Between 1970 and 2106 the only century year that is not a leap year is 2100.
   function automatic logic is_leap(input logic [11:0] year);
      return (year[1:0] == 2'b00) && (year != SkipLeapYear);
   endfunction

   function automatic logic [OpW-1:0] month_len(input logic [3:0] mon, input logic leap);
      logic [OpW-1:0] len;
      case (mon)
         4'd1:    len = leap ? 33'd29 : 33'd28;
         4'd3:    len = 33'd30;
         4'd5:    len = 33'd30;
         4'd8:    len = 33'd30;
         4'd10:   len = 33'd30;
         default: len = 33'd31;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/ep2cal_sub.sv @@
// Shared compare and subtract unit used by every step of the conversion.
// Depends on ep2cal_pkg.
`timescale 1ns / 1ps

module ep2cal_sub (
   input  logic [ep2cal_pkg::OpW-1:0] op_a,
   input  logic [ep2cal_pkg::OpW-1:0] op_b,
   output ep2cal_pkg::sub_out_type    res
);

   logic [ep2cal_pkg::OpW:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign res.diff  = wide_diff[ep2cal_pkg::OpW-1:0];
   assign res.ge    = ~wide_diff[ep2cal_pkg::OpW];

endmodule

@@ rtl/ep2cal_core.sv @@
// Sequencer and working registers that drive the shared subtract unit through
// the day, time, year, month and weekday steps. Depends on ep2cal_pkg and ep2cal_sub.
`timescale 1ns / 1ps

module ep2cal_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         secs,
   input  logic                load_ok,
   output logic                busy,
   output logic                done,
   output ep2cal_pkg::cal_type result
);

   ep2cal_pkg::state_type state_ff, state_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] days_ff, days_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  min_ff, min_in;
   logic [5:0]  sec_ff, sec_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  mday_ff, mday_in;
   logic [2:0]  wday_ff, wday_in;

   logic [ep2cal_pkg::OpW-1:0] op_a, op_b;
   ep2cal_pkg::sub_out_type    sub_res;
   logic [31:0]                acc_step;
   logic [15:0]                quo_step;
   logic                       leap;

   ep2cal_sub u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .res  (sub_res)
   );

   assign leap     = ep2cal_pkg::is_leap(year_ff);
   assign op_a     = {1'b0, acc_ff};
   assign acc_step = sub_res.ge ? sub_res.diff[31:0] : acc_ff;
   assign quo_step = {quo_ff[14:0], sub_res.ge};

   always_comb begin
      case (state_ff)
         ep2cal_pkg::ST_DAYS:  op_b = ep2cal_pkg::DaySecs << cnt_ff;
         ep2cal_pkg::ST_HOUR:  op_b = ep2cal_pkg::HourSecs << cnt_ff;
         ep2cal_pkg::ST_MIN:   op_b = ep2cal_pkg::MinSecs << cnt_ff;
         ep2cal_pkg::ST_YEAR:  op_b = leap ? ep2cal_pkg::LeapLen : ep2cal_pkg::YearLen;
         ep2cal_pkg::ST_MONTH: op_b = ep2cal_pkg::month_len(mon_ff, leap);
         ep2cal_pkg::ST_WDAY:  op_b = ep2cal_pkg::WeekLen << cnt_ff;
         default:              op_b = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      days_in  = days_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      year_in  = year_ff;
      mon_in   = mon_ff;
      mday_in  = mday_ff;
      wday_in  = wday_ff;
      case (state_ff)
         ep2cal_pkg::ST_IDLE: begin
            if (start) begin
               acc_in   = secs;
               quo_in   = '0;
               cnt_in   = ep2cal_pkg::DayBitTop;
               state_in = ep2cal_pkg::ST_DAYS;
            end
         end
         ep2cal_pkg::ST_DAYS: begin
            acc_in = acc_step;
            quo_in = quo_step;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == 4'd0) begin
               days_in  = quo_step;
               cnt_in   = ep2cal_pkg::HourBitTop;
               state_in = ep2cal_pkg::ST_HOUR;
            end
         end
         ep2cal_pkg::ST_HOUR: begin
            acc_in = acc_step;
            quo_in = quo_step;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == 4'd0) begin
               hour_in  = quo_step[4:0];
               cnt_in   = ep2cal_pkg::MinBitTop;
               state_in = ep2cal_pkg::ST_MIN;
            end
         end
         ep2cal_pkg::ST_MIN: begin
            acc_in = acc_step;
            quo_in = quo_step;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == 4'd0) begin
               min_in   = quo_step[5:0];
               sec_in   = acc_step[5:0];
               acc_in   = {16'd0, days_ff};
               year_in  = ep2cal_pkg::EpochYear;
               state_in = ep2cal_pkg::ST_YEAR;
            end
         end
         ep2cal_pkg::ST_YEAR: begin
            if (sub_res.ge) begin
               acc_in  = sub_res.diff[31:0];
               year_in = 12'(year_ff + 12'd1);
            end else begin
               mon_in   = '0;
               state_in = ep2cal_pkg::ST_MONTH;
            end
         end
         ep2cal_pkg::ST_MONTH: begin
            if (sub_res.ge && (mon_ff != ep2cal_pkg::LastMonth)) begin
               acc_in = sub_res.diff[31:0];
               mon_in = 4'(mon_ff + 4'd1);
            end else begin
               mday_in  = 5'(acc_ff[4:0] + 5'd1);
               acc_in   = 32'({16'd0, days_ff} + ep2cal_pkg::EpochWeekday);
               cnt_in   = ep2cal_pkg::WdayBitTop;
               state_in = ep2cal_pkg::ST_WDAY;
            end
         end
         ep2cal_pkg::ST_WDAY: begin
            acc_in = acc_step;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == 4'd0) begin
               wday_in  = acc_step[2:0];
               state_in = ep2cal_pkg::ST_DONE;
            end
         end
         ep2cal_pkg::ST_DONE: begin
            if (load_ok) begin
               state_in = ep2cal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ep2cal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ep2cal_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      days_ff <= days_in;
      hour_ff <= hour_in;
      min_ff  <= min_in;
      sec_ff  <= sec_in;
      year_ff <= year_in;
      mon_ff  <= mon_in;
      mday_ff <= mday_in;
      wday_ff <= wday_in;
   end

   assign busy = (state_ff != ep2cal_pkg::ST_IDLE);
   assign done = (state_ff == ep2cal_pkg::ST_DONE);

   assign result.year    = year_ff;
   assign result.month   = 4'(mon_ff + 4'd1);
   assign result.day     = mday_ff;
   assign result.hour    = hour_ff;
   assign result.minute  = min_ff;
   assign result.second  = sec_ff;
   assign result.weekday = wday_ff;

endmodule

@@ rtl/epoch_seconds_to_calendar_top.sv @@
// Top level of the epoch seconds to calendar converter: request handshake and
// the result output register. Depends on ep2cal_pkg and ep2cal_core.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_seconds_count
//   rsp_      out        rsp_valid/rsp_stall  rsp_cal_year .. rsp_cal_weekday
//
// One beat passes through the day, hour, minute, year, month and weekday steps, in
// that order, from acceptance to the result register.
// Every step runs through the single shared compare and subtract unit.
// Reset is synchronous and clears the sequencer and the result valid flag.
// A new request is taken while a finished result still waits on rsp_stall.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_seconds_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_cal_year,
   output logic [3:0]  rsp_cal_month,
   output logic [4:0]  rsp_cal_day,
   output logic [4:0]  rsp_cal_hour,
   output logic [5:0]  rsp_cal_minute,
   output logic [5:0]  rsp_cal_second,
   output logic [2:0]  rsp_cal_weekday
);

   logic                core_busy;
   logic                core_done;
   logic                start;
   logic                load;
   logic                out_free;
   ep2cal_pkg::cal_type core_result;
   ep2cal_pkg::cal_type rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_stall = core_busy | reset;
   assign start     = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign load      = core_done & out_free;

   ep2cal_core u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .secs    (req_seconds_count),
      .load_ok (out_free),
      .busy    (core_busy),
      .done    (core_done),
      .result  (core_result)
   );

   assign rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   assign rsp_data_in  = load ? core_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cal_year    = rsp_data_ff.year;
   assign rsp_cal_month   = rsp_data_ff.month;
   assign rsp_cal_day     = rsp_data_ff.day;
   assign rsp_cal_hour    = rsp_data_ff.hour;
   assign rsp_cal_minute  = rsp_data_ff.minute;
   assign rsp_cal_second  = rsp_data_ff.second;
   assign rsp_cal_weekday = rsp_data_ff.weekday;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("request accepted but converter not busy next cycle");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_month >= 4'd1) && (rsp_cal_month <= 4'd12))
      else $error("result month out of range");

   a_day_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_day >= 5'd1) && (rsp_cal_weekday <= 3'd6))
      else $error("result day or weekday out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cal_year >= 12'd1970) && (rsp_cal_year <= 12'd2106))
      else $error("result year out of range");
`endif

endmodule
